[rtl/q2e_pkg.sv]
// Shared constants, lane type and CORDIC step for the quaternion to Euler converter.
`timescale 1ns / 1ps
package q2e_pkg;

   localparam int Q2E_COMPONENT_BITS = 16;
   localparam int Q2E_ANGLE_BITS     = 16;
   localparam int Q2E_ROTATION_STEPS = 16;

   // CORDIC datapath widths (operands arrive rescaled to below 2^29)
   localparam int CW = 36;
   localparam int ZW = 36;

   // angles in units of 2^-30 rad
   localparam longint ANG_PI      = 64'sd3373259426;
   localparam longint ANG_HALF_PI = 64'sd1686629713;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } cordic_lane_type;

   function automatic cordic_lane_type cordic_step(input cordic_lane_type a,
                                                   input logic [4:0] sh);
      cordic_lane_type      r;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [ZW-1:0] t;
      r  = a;
      dx = a.y >>> sh;
      dy = a.x >>> sh;
      t  = signed'(ZW'(ATAN_TAB[sh]));
      if (a.y > 0) begin
         r.x = a.x + dx;
         r.y = a.y - dy;
         r.z = a.z + t;
      end else begin
         r.x = a.x - dx;
         r.y = a.y + dy;
         r.z = a.z - t;
      end
      return r;
   endfunction

endpackage

[rtl/quaternion_to_euler.sv]
// Top level: pipelined quaternion to roll, pitch and yaw converter.
`timescale 1ns / 1ps
// Converts a Q1.14 quaternion to roll and yaw in Q2.13 radians and pitch in Q1.13 radians.
// The block is a fixed pipeline that takes one quaternion every clock cycle; busy is always
// low. Each result appears on the rsp_ ports with rsp_valid for one cycle, after the
// pipeline's stages: two product and sum stages, one stage per result bit of the 31-bit
// square roots for pitch, one operand setup stage, one stage per CORDIC rotation and an
// output stage.
// Results cannot be held off; a result not taken in its cycle is gone.
module quaternion_to_euler #(
   parameter int COMPONENT_BITS = q2e_pkg::Q2E_COMPONENT_BITS,
   parameter int ANGLE_BITS     = q2e_pkg::Q2E_ANGLE_BITS,
   parameter int ROTATION_STEPS = q2e_pkg::Q2E_ROTATION_STEPS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_x,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_y,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_z,
   input  logic signed [COMPONENT_BITS-1:0] req_quat_w,
   output logic                             rsp_valid,
   output logic signed [ANGLE_BITS-1:0]     rsp_roll,
   output logic signed [ANGLE_BITS-2:0]     rsp_pitch,
   output logic signed [ANGLE_BITS-1:0]     rsp_yaw
);
   import q2e_pkg::*;

   localparam int CB     = COMPONENT_BITS;
   localparam int PW     = 2 * CB;
   localparam int SW     = PW + 2;
   localparam int RW     = 33;
   localparam int RSH_R  = (PW > 32) ? PW - 32 : 0;
   localparam int RSH_L  = (PW > 32) ? 0 : 32 - PW;
   localparam int RAD_W  = 62;
   localparam int ROOT_STEPS = RAD_W / 2;
   localparam int REM_W  = ROOT_STEPS + 2;
   localparam int NR     = (ROTATION_STEPS < 32) ? ROTATION_STEPS : 32;
   localparam int OW     = ZW + 1;
   localparam int LATENCY = ROOT_STEPS + NR + 4;
   localparam logic signed [SW-1:0] ONE = SW'(1) <<< (PW - 6);
   localparam longint LIM_PI   = (ANG_PI + (64'sd1 <<< (32 - ANGLE_BITS))) >>> (33 - ANGLE_BITS);
   localparam longint LIM_HALF =
      (ANG_HALF_PI + (64'sd1 <<< (32 - ANGLE_BITS))) >>> (33 - ANGLE_BITS);
   localparam logic signed [OW-1:0] RND = OW'(1) <<< (32 - ANGLE_BITS);

   typedef struct packed {
      logic signed [PW-1:0] wx;
      logic signed [PW-1:0] yz;
      logic signed [PW-1:0] xx;
      logic signed [PW-1:0] yy;
      logic signed [PW-1:0] zz;
      logic signed [PW-1:0] wz;
      logic signed [PW-1:0] xy;
   } prod_type;

   typedef struct packed {
      logic signed [RW-1:0]    num_r;
      logic signed [RW-1:0]    den_r;
      logic signed [RW-1:0]    num_y;
      logic signed [RW-1:0]    den_y;
      logic [RAD_W-1:0]        rad_a;
      logic [RAD_W-1:0]        rad_b;
      logic [REM_W-1:0]        rem_a;
      logic [REM_W-1:0]        rem_b;
      logic [ROOT_STEPS-1:0]   root_a;
      logic [ROOT_STEPS-1:0]   root_b;
   } mid_type;

   function automatic logic signed [RW-1:0] rescale(input logic signed [SW-1:0] v);
      logic signed [SW+RW-1:0] e;
      e = signed'({{RW{v[SW-1]}}, v});
      e = (e >>> RSH_R) <<< RSH_L;
      return e[RW-1:0];
   endfunction

   function automatic cordic_lane_type make_lane(input logic signed [RW-1:0] num,
                                                 input logic signed [RW-1:0] den);
      cordic_lane_type r;
      r.zero = (num == '0) && (den == '0);
      if (den < 0) begin
         r.x = -CW'(den);
         r.y = -CW'(num);
         r.z = (num >= 0) ? ZW'(ANG_PI) : -ZW'(ANG_PI);
      end else begin
         r.x = CW'(den);
         r.y = CW'(num);
         r.z = '0;
      end
      return r;
   endfunction

   function automatic logic signed [OW-1:0] finish(input logic signed [OW-1:0] a,
                                                   input longint lim);
      logic signed [OW-1:0] v;
      logic signed [OW-1:0] l;
      v = (a + RND) >>> (33 - ANGLE_BITS);
      l = OW'(lim);
      if (v > l) v = l;
      if (v < -l) v = -l;
      return v;
   endfunction

   function automatic void sqrt_step(input logic [REM_W-1:0] rem,
                                     input logic [ROOT_STEPS-1:0] root,
                                     input logic [1:0] bits,
                                     output logic [REM_W-1:0] rem_o,
                                     output logic [ROOT_STEPS-1:0] root_o);
      logic [REM_W+1:0] rt;
      logic [REM_W+1:0] trial;
      rt    = {rem, bits};
      trial = (REM_W+2)'({root, 2'b01});
      if (rt >= trial) begin
         rem_o  = REM_W'(rt - trial);
         root_o = {root[ROOT_STEPS-2:0], 1'b1};
      end else begin
         rem_o  = REM_W'(rt);
         root_o = {root[ROOT_STEPS-2:0], 1'b0};
      end
   endfunction

   // stage 1: products
   logic     prod_valid_ff;
   prod_type prod_ff;
   prod_type prod_in;

   always_comb begin
      prod_in.wx = PW'(req_quat_w) * PW'(req_quat_x);
      prod_in.yz = PW'(req_quat_y) * PW'(req_quat_z);
      prod_in.xx = PW'(req_quat_x) * PW'(req_quat_x);
      prod_in.yy = PW'(req_quat_y) * PW'(req_quat_y);
      prod_in.zz = PW'(req_quat_z) * PW'(req_quat_z);
      prod_in.wz = PW'(req_quat_w) * PW'(req_quat_z);
      prod_in.xy = PW'(req_quat_x) * PW'(req_quat_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= start;
      end
      prod_ff <= prod_in;
   end

   // stage 2: sums, rescale, radicands
   logic    mid_valid_ff [ROOT_STEPS+1];
   mid_type mid_ff [ROOT_STEPS+1];
   mid_type mid_in [ROOT_STEPS+1];

   always_comb begin
      logic signed [SW-1:0] h_wx, h_yz, h_xx, h_yy, h_zz, h_wz, h_xy, th, ra, rb;
      logic signed [RW-1:0] sa, sb;
      h_wx = SW'(prod_ff.wx >>> 1);
      h_yz = SW'(prod_ff.yz >>> 1);
      h_xx = SW'(prod_ff.xx >>> 1);
      h_yy = SW'(prod_ff.yy >>> 1);
      h_zz = SW'(prod_ff.zz >>> 1);
      h_wz = SW'(prod_ff.wz >>> 1);
      h_xy = SW'(prod_ff.xy >>> 1);
      th = h_wx - h_yz;
      ra = ONE + th;
      rb = ONE - th;
      if (ra < 0) ra = '0;
      if (rb < 0) rb = '0;
      sa = rescale(ra);
      sb = rescale(rb);
      mid_in[0].num_r  = rescale(h_wx + h_yz);
      mid_in[0].den_r  = rescale(ONE - h_xx - h_yy);
      mid_in[0].num_y  = rescale(h_wz + h_xy);
      mid_in[0].den_y  = rescale(ONE - h_yy - h_zz);
      mid_in[0].rad_a  = {sa[31:0], 30'b0};
      mid_in[0].rad_b  = {sb[31:0], 30'b0};
      mid_in[0].rem_a  = '0;
      mid_in[0].rem_b  = '0;
      mid_in[0].root_a = '0;
      mid_in[0].root_b = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff[0] <= 1'b0;
      end else begin
         mid_valid_ff[0] <= prod_valid_ff;
      end
      mid_ff[0] <= mid_in[0];
   end

   // square root stages, one root bit each
   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_sqrt
      always_comb begin
         mid_in[k+1] = mid_ff[k];
         sqrt_step(mid_ff[k].rem_a, mid_ff[k].root_a, mid_ff[k].rad_a[RAD_W-1-2*k -: 2],
                   mid_in[k+1].rem_a, mid_in[k+1].root_a);
         sqrt_step(mid_ff[k].rem_b, mid_ff[k].root_b, mid_ff[k].rad_b[RAD_W-1-2*k -: 2],
                   mid_in[k+1].rem_b, mid_in[k+1].root_b);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            mid_valid_ff[k+1] <= 1'b0;
         end else begin
            mid_valid_ff[k+1] <= mid_valid_ff[k];
         end
         mid_ff[k+1] <= mid_in[k+1];
      end
   end

   // CORDIC operand setup and rotation stages
   logic            rot_valid_ff [NR+1];
   cordic_lane_type roll_ff  [NR+1];
   cordic_lane_type pitch_ff [NR+1];
   cordic_lane_type yaw_ff   [NR+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_valid_ff[0] <= 1'b0;
      end else begin
         rot_valid_ff[0] <= mid_valid_ff[ROOT_STEPS];
      end
      roll_ff[0]  <= make_lane(mid_ff[ROOT_STEPS].num_r, mid_ff[ROOT_STEPS].den_r);
      yaw_ff[0]   <= make_lane(mid_ff[ROOT_STEPS].num_y, mid_ff[ROOT_STEPS].den_y);
      pitch_ff[0] <= make_lane(RW'(mid_ff[ROOT_STEPS].root_a),
                               RW'(mid_ff[ROOT_STEPS].root_b));
   end

   for (genvar i = 0; i < NR; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (reset) begin
            rot_valid_ff[i+1] <= 1'b0;
         end else begin
            rot_valid_ff[i+1] <= rot_valid_ff[i];
         end
         roll_ff[i+1]  <= cordic_step(roll_ff[i], 5'(i));
         pitch_ff[i+1] <= cordic_step(pitch_ff[i], 5'(i));
         yaw_ff[i+1]   <= cordic_step(yaw_ff[i], 5'(i));
      end
   end

   // output stage
   logic signed [OW-1:0] roll_in, pitch_in, yaw_in;
   logic                 rsp_valid_ff;
   logic signed [ANGLE_BITS-1:0] rsp_roll_ff, rsp_yaw_ff;
   logic signed [ANGLE_BITS-2:0] rsp_pitch_ff;

   always_comb begin
      logic signed [OW-1:0] zr, zp, zy;
      zr = roll_ff[NR].zero  ? '0 : OW'(roll_ff[NR].z);
      zp = pitch_ff[NR].zero ? '0 : OW'(pitch_ff[NR].z);
      zy = yaw_ff[NR].zero   ? '0 : OW'(yaw_ff[NR].z);
      roll_in  = finish(zr, LIM_PI);
      pitch_in = finish((zp <<< 1) - OW'(ANG_HALF_PI), LIM_HALF);
      yaw_in   = finish(zy, LIM_PI);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rot_valid_ff[NR];
      end
      rsp_roll_ff  <= roll_in[ANGLE_BITS-1:0];
      rsp_pitch_ff <= pitch_in[ANGLE_BITS-2:0];
      rsp_yaw_ff   <= yaw_in[ANGLE_BITS-1:0];
   end

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_roll  = rsp_roll_ff;
   assign rsp_pitch = rsp_pitch_ff;
   assign rsp_yaw   = rsp_yaw_ff;

endmodule

[rtl/q2e_chk.sv]
// Port-level checker for the quaternion to Euler converter, with its bind.
`timescale 1ns / 1ps
module q2e_chk #(
   parameter int ANGLE_BITS = q2e_pkg::Q2E_ANGLE_BITS,
   parameter int LATENCY    = 51
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic signed [ANGLE_BITS-1:0] rsp_roll,
   input logic signed [ANGLE_BITS-2:0] rsp_pitch
);
   import q2e_pkg::*;

   localparam longint LIM_PI   = (ANG_PI + (64'sd1 <<< (32 - ANGLE_BITS))) >>> (33 - ANGLE_BITS);
   localparam longint LIM_HALF =
      (ANG_HALF_PI + (64'sd1 <<< (32 - ANGLE_BITS))) >>> (33 - ANGLE_BITS);

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without matching transfer");

   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("transfer lost");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (longint'(rsp_roll) <= LIM_PI) && (longint'(rsp_roll) >= -LIM_PI)
                    && (longint'(rsp_pitch) <= LIM_HALF) && (longint'(rsp_pitch) >= -LIM_HALF))
      else $error("angle out of range");

endmodule

bind quaternion_to_euler q2e_chk #(
   .ANGLE_BITS(ANGLE_BITS),
   .LATENCY   (LATENCY)
) u_q2e_chk (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp_roll (rsp_roll),
   .rsp_pitch(rsp_pitch)
);
